// File: rtl/core/tbim_pkg.sv
// Package for the two-body invariant mass block: widths and register indexes
// used by the top level.
// No dependencies.
`default_nettype none
package tbim_pkg;
   localparam int MomentumBitsDefault = 20;
   localparam int MassBits = 16;
   localparam int InvMassBits = 22;
   localparam int CsrIndexBits = 8;
   localparam logic [CsrIndexBits-1:0] CsrMassHypA = 8'd0;
   localparam logic [CsrIndexBits-1:0] CsrMassHypB = 8'd1;
endpackage
`default_nettype wire

// File: rtl/core/tbim_sqrt_cell.sv
// One cell of a pipelined restoring square root: settles one result bit
// per cycle while adv is high, handing remainder, partial root and side data on.
// Depends on nothing beyond its parameters.
`default_nettype none
module tbim_sqrt_cell #(
   parameter int RadBits  = 64,
   parameter int RootBits = 32,
   parameter int Step     = 0,
   parameter int SideBits = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic                valid_in,
   input  wire logic [RadBits-1:0]  rem_in,
   input  wire logic [RootBits-1:0] root_in,
   input  wire logic [SideBits-1:0] side_in,
   output logic                     valid_out,
   output logic [RadBits-1:0]       rem_out,
   output logic [RootBits-1:0]      root_out,
   output logic [SideBits-1:0]      side_out
);
   localparam int Bit = RootBits - 1 - Step;
   logic [RadBits+1:0] trial;
   logic [RadBits+1:0] rem_wide;
   logic               valid_ff;
   logic [RadBits-1:0] rem_ff, rem_in_n;
   logic [RootBits-1:0] root_ff, root_in_n;
   logic [SideBits-1:0] side_ff;

   always_comb begin
      trial = ({{(RadBits+2-RootBits){1'b0}}, root_in} << (Bit + 1))
            | ((RadBits+2)'(1) << (2 * Bit));
      rem_wide = {2'b00, rem_in};
      if (rem_wide >= trial) begin
         rem_in_n  = RadBits'(rem_wide - trial);
         root_in_n = root_in | (RootBits'(1) << Bit);
      end else begin
         rem_in_n  = rem_in;
         root_in_n = root_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
      if (adv) begin
         rem_ff  <= rem_in_n;
         root_ff <= root_in_n;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;
   assign side_out  = side_ff;
endmodule
`default_nettype wire

// File: rtl/core/tbim_sqrt_chain.sv
// A row of square-root cells: one result bit per cell, one item per cycle while adv is high.
// Depends on tbim_sqrt_cell.
`default_nettype none
module tbim_sqrt_chain #(
   parameter int RadBits  = 64,
   parameter int RootBits = 32,
   parameter int SideBits = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic                valid_in,
   input  wire logic [RadBits-1:0]  rad_in,
   input  wire logic [SideBits-1:0] side_in,
   output logic                     valid_out,
   output logic [RootBits-1:0]      root_out,
   output logic [SideBits-1:0]      side_out
);
   logic                v [RootBits+1];
   logic [RadBits-1:0]  r [RootBits+1];
   logic [RootBits-1:0] q [RootBits+1];
   logic [SideBits-1:0] s [RootBits+1];

   assign v[0] = valid_in;
   assign r[0] = rad_in;
   assign q[0] = '0;
   assign s[0] = side_in;

   for (genvar i = 0; i < RootBits; i++) begin : g_cell
      tbim_sqrt_cell #(
         .RadBits(RadBits), .RootBits(RootBits), .Step(i), .SideBits(SideBits)
      ) u_cell (
         .clock(clock), .reset(reset), .adv(adv),
         .valid_in(v[i]), .rem_in(r[i]), .root_in(q[i]), .side_in(s[i]),
         .valid_out(v[i+1]), .rem_out(r[i+1]), .root_out(q[i+1]),
         .side_out(s[i+1])
      );
   end

   assign valid_out = v[RootBits];
   assign root_out  = q[RootBits];
   assign side_out  = s[RootBits];
endmodule
`default_nettype wire

// File: rtl/core/two_body_invariant_mass.sv
// Top level of the two-body invariant mass block: squares, two energy
// square-root chains, the mass square-root chain and the output register.
// Depends on tbim_pkg and tbim_sqrt_chain.
//
// Usage: an item is transferred on req_ when req_valid is high and req_stall
// low; it carries both tracks' momenta. Each item yields exactly one result
// transfer on rsp_ (inv_mass, negative_flag), in order. The pipeline moves
// as a whole: one item can enter every cycle while req_stall is low, so
// throughput is then one item per clock. The path holds 3 + E + 1 + M + 1
// register stages, where E and M are the bit counts of the energy and mass
// square-root cell rows (one bit per cell), 21 and 22 at the default width.
// That is 48 stages. When the receiver raises rsp_stall while the output
// register is full, that register holds its result, the whole pipeline
// freezes with it and req_stall rises; a result waiting there does not
// block new items while the output is free or being taken. Reset empties
// the pipeline and sets both mass hypotheses to 106 MeV. csr_ writes are
// always ready.
`default_nettype none
module two_body_invariant_mass #(
   parameter int MOMENTUM_BITS = tbim_pkg::MomentumBitsDefault
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [MOMENTUM_BITS-1:0]     req_px_a,
   input  wire logic signed [MOMENTUM_BITS-1:0]     req_py_a,
   input  wire logic signed [MOMENTUM_BITS-1:0]     req_pz_a,
   input  wire logic signed [MOMENTUM_BITS-1:0]     req_px_b,
   input  wire logic signed [MOMENTUM_BITS-1:0]     req_py_b,
   input  wire logic signed [MOMENTUM_BITS-1:0]     req_pz_b,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [tbim_pkg::InvMassBits-1:0]         rsp_inv_mass,
   output logic                                     rsp_negative_flag,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tbim_pkg::CsrIndexBits-1:0]   csr_index,
   input  wire logic [31:0]                         csr_data
);
   import tbim_pkg::*;

   localparam int MB = MOMENTUM_BITS;
   localparam int MagBits = MB;                 // |p| <= 2^(MB-1)
   localparam int SqBits = 2 * MagBits;         // one component squared
   localparam int RadEBits = (SqBits + 2 > 2 * MassBits + 2) ? SqBits + 2
                           : 2 * MassBits + 2;  // m^2 + 3 squares
   localparam int EBits = RadEBits / 2;         // energy root bits
   localparam int ESumBits = EBits + 1;
   localparam int E2Bits = 2 * ESumBits;
   localparam int SMagBits = MB + 1;            // |pa+pb|
   localparam int P2Bits = 2 * SMagBits + 2;
   localparam int P2Half = P2Bits / 2;
   localparam int RadMBits = (E2Bits > P2Bits) ? E2Bits : P2Bits;
   localparam int MBitsR = RadMBits / 2;

   logic adv;
   logic rsp_valid_ff;
   logic [InvMassBits-1:0] rsp_mass_ff;
   logic rsp_neg_ff;
   logic [MassBits-1:0] mass_a_ff, mass_b_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_a_ff <= MassBits'(106);
         mass_b_ff <= MassBits'(106);
      end else if (csr_valid) begin
         if (csr_index == CsrMassHypA) mass_a_ff <= csr_data[MassBits-1:0];
         if (csr_index == CsrMassHypB) mass_b_ff <= csr_data[MassBits-1:0];
      end
   end

   function automatic logic [MagBits:0] mag(input logic signed [MB:0] v);
      logic [MB:0] t;
      t = v[MB] ? MB'(0) - v : v;
      return t;
   endfunction

   // Stage 1: magnitudes of components and of pair sums.
   logic s1_v;
   logic [MagBits:0] a_ff [3];
   logic [MagBits:0] b_ff [3];
   logic [MagBits:0] c_ff [3];
   logic [MassBits-1:0] ma1_ff, mb1_ff;
   logic signed [MB:0] ea [3];
   logic signed [MB:0] eb [3];

   always_comb begin
      ea[0] = {req_px_a[MB-1], req_px_a}; ea[1] = {req_py_a[MB-1], req_py_a};
      ea[2] = {req_pz_a[MB-1], req_pz_a};
      eb[0] = {req_px_b[MB-1], req_px_b}; eb[1] = {req_py_b[MB-1], req_py_b};
      eb[2] = {req_pz_b[MB-1], req_pz_b};
   end

   // Stage 2: squares. Stage 3: sums.
   logic s2_v, s3_v;
   logic [2*(MagBits+1)-1:0] sa_ff [3];
   logic [2*(MagBits+1)-1:0] sb_ff [3];
   logic [2*(MagBits+1)-1:0] sc_ff [3];
   logic [2*MassBits-1:0] m2a_ff, m2b_ff;
   logic [RadEBits-1:0] rada_ff, radb_ff;
   logic [P2Bits-1:0] p2_ff, p2_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0;
      end else if (adv) begin
         s1_v <= req_valid; s2_v <= s1_v; s3_v <= s2_v;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            a_ff[i] <= mag(ea[i]);
            b_ff[i] <= mag(eb[i]);
            c_ff[i] <= mag(ea[i] + eb[i]);
            sa_ff[i] <= a_ff[i] * a_ff[i];
            sb_ff[i] <= b_ff[i] * b_ff[i];
            sc_ff[i] <= c_ff[i] * c_ff[i];
         end
         ma1_ff <= mass_a_ff; mb1_ff <= mass_b_ff;
         m2a_ff <= ma1_ff * ma1_ff; m2b_ff <= mb1_ff * mb1_ff;
         rada_ff <= RadEBits'(m2a_ff) + RadEBits'(sa_ff[0]) + RadEBits'(sa_ff[1])
                  + RadEBits'(sa_ff[2]);
         radb_ff <= RadEBits'(m2b_ff) + RadEBits'(sb_ff[0]) + RadEBits'(sb_ff[1])
                  + RadEBits'(sb_ff[2]);
         p2_ff <= P2Bits'(sc_ff[0]) + P2Bits'(sc_ff[1]) + P2Bits'(sc_ff[2]);
      end
   end

   // The momentum sum squared travels alongside the energies, one half in
   // each chain.
   logic e_v;
   logic [EBits-1:0] ea_root, eb_root;
   logic eb_v;
   logic [P2Half-1:0] p2_hi, p2_lo;

   tbim_sqrt_chain #(.RadBits(RadEBits), .RootBits(EBits), .SideBits(P2Half))
   u_energy_a (
      .clock(clock), .reset(reset), .adv(adv), .valid_in(s3_v),
      .rad_in(rada_ff), .side_in(p2_ff[P2Bits-1:P2Half]),
      .valid_out(e_v), .root_out(ea_root), .side_out(p2_hi)
   );
   tbim_sqrt_chain #(.RadBits(RadEBits), .RootBits(EBits), .SideBits(P2Half))
   u_energy_b (
      .clock(clock), .reset(reset), .adv(adv), .valid_in(s3_v),
      .rad_in(radb_ff), .side_in(p2_ff[P2Half-1:0]),
      .valid_out(eb_v), .root_out(eb_root), .side_out(p2_lo)
   );

   assign p2_q = {p2_hi, p2_lo};

   // Energy sum squared and subtraction.
   logic d_v;
   logic [ESumBits-1:0] esum;
   logic [E2Bits-1:0] e2;
   logic [RadMBits-1:0] diff_ff;
   logic neg_ff;

   always_comb begin
      esum = ESumBits'(ea_root) + ESumBits'(eb_root);
      e2 = esum * esum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v <= 1'b0;
      end else if (adv) begin
         d_v <= e_v;
      end
      if (adv) begin
         if (RadMBits'(e2) < RadMBits'(p2_q)) begin
            neg_ff <= 1'b1; diff_ff <= '0;
         end else begin
            neg_ff <= 1'b0; diff_ff <= RadMBits'(e2) - RadMBits'(p2_q);
         end
      end
   end

   logic m_v, m_neg;
   logic [MBitsR-1:0] m_root;

   tbim_sqrt_chain #(.RadBits(RadMBits), .RootBits(MBitsR), .SideBits(1))
   u_mass (
      .clock(clock), .reset(reset), .adv(adv), .valid_in(d_v),
      .rad_in(diff_ff), .side_in(neg_ff),
      .valid_out(m_v), .root_out(m_root), .side_out(m_neg)
   );

   localparam int RW = (MBitsR > InvMassBits) ? MBitsR : InvMassBits;
   logic [RW-1:0] m_wide;
   assign m_wide = RW'(m_root);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= m_v;
      end
      if (adv) begin
         rsp_neg_ff <= m_neg;
         rsp_mass_ff <= (m_wide > RW'({InvMassBits{1'b1}})) ? {InvMassBits{1'b1}}
                        : InvMassBits'(m_wide);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_inv_mass = rsp_mass_ff;
   assign rsp_negative_flag = rsp_neg_ff;

   a_neg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_negative_flag |-> rsp_inv_mass == '0)
      else $error("negative flag with nonzero mass");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_inv_mass))
      else $error("stalled result changed");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output stall");
   a_lanes: assert property (@(posedge clock) disable iff (reset)
      e_v == eb_v)
      else $error("energy chains out of step");
endmodule
`default_nettype wire
